FILE: hdl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared codes, fixed-point helpers and hammer table maths for the ring model
// ----------------------------------------------------------------------------
package msr_pkg;

    // request kinds carried on tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_STRIKE = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_INV_MASS  = 3'd0;
    localparam logic [2:0] CFG_NEIGHBOUR = 3'd1;
    localparam logic [2:0] CFG_CENTERING = 3'd2;
    localparam logic [2:0] CFG_DAMPING   = 3'd3;
    localparam logic [2:0] CFG_TIME_STEP = 3'd4;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    typedef logic signed [31:0] sample_t;
    typedef logic signed [63:0] wide_t;

    // shift right by k, rounding half up
    function automatic wide_t rnd(input wide_t x, input int k);
        wide_t half;
        half = 64'sd1 <<< (k - 1);
        return (x + half) >>> k;
    endfunction

    // saturate to the signed 32-bit range
    function automatic sample_t sat32(input wide_t x);
        sample_t r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // sine on [0, pi/2], argument and result in q2.30
    function automatic longint sin_poly(input longint x);
        longint x2;
        longint t;
        x2 = rnd(x * x, 30);
        t  = ONE_Q30;
        t  = ONE_Q30 - rnd(x2 * t, 30) / 72;
        t  = ONE_Q30 - rnd(x2 * t, 30) / 42;
        t  = ONE_Q30 - rnd(x2 * t, 30) / 20;
        t  = ONE_Q30 - rnd(x2 * t, 30) / 6;
        return rnd(x * t, 30);
    endfunction

endpackage

FILE: hdl/msr_ram.sv
// ----------------------------------------------------------------------------
// msr_ram
// Generic single write port, single read port RAM with registered read data
// ----------------------------------------------------------------------------
module msr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/msr_hammer_rom.sv
// ----------------------------------------------------------------------------
// msr_hammer_rom
// Constant hammer shape table, two shapes read at one mass index
// ----------------------------------------------------------------------------
module msr_hammer_rom
    import msr_pkg::*;
#(
    parameter int NUM_MASSES = 20,
    parameter int NUM_SHAPES = 4
) (
    input  logic [$clog2(NUM_SHAPES)-1:0] a_sel,
    input  logic [$clog2(NUM_SHAPES)-1:0] b_sel,
    input  logic [$clog2(NUM_MASSES)-1:0] idx,
    output sample_t                       a_val,
    output sample_t                       b_val
);

    sample_t rom [NUM_SHAPES][NUM_MASSES];

    // table contents worked out at elaboration
    for (genvar k = 0; k < NUM_SHAPES; k++)
    begin : g_shape
        for (genvar i = 0; i < NUM_MASSES; i++)
        begin : g_mass
            localparam int     M4   = 4 * i;
            localparam int     QD   = M4 / NUM_MASSES;
            localparam int     RM   = M4 % NUM_MASSES;
            localparam int     MS   = ((QD % 2) == 1) ? NUM_MASSES - RM : RM;
            localparam longint XA   = HALF_PI_Q30 * MS / NUM_MASSES;
            localparam longint SN   = rnd(sin_poly(XA), 14);
            localparam longint SINV = (((QD / 2) % 2) == 1) ? -SN : SN;
            localparam longint STEP = (i > NUM_MASSES / 2) ? 64'sd65536 : -64'sd65536;
            localparam longint RAMP = (longint'(i) * 262144 + NUM_MASSES)
                                      / (2 * NUM_MASSES) - 65536;
            localparam longint VAL  = ((k % 4) == 1) ? STEP :
                                      ((k % 4) == 2) ? RAMP : SINV;
            assign rom[k][i] = 32'(VAL);
        end
    end

    assign a_val = rom[a_sel][idx];
    assign b_val = rom[b_sel][idx];

endmodule

FILE: hdl/mass_spring_ring_simulator.sv
// ----------------------------------------------------------------------------
// mass_spring_ring_simulator
// Ring of masses with tick, strike and sample requests on one shared multiplier
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, the kind in tuser: tick runs one
// semi-implicit Euler step over the ring, strike blends positions toward an
// interpolated hammer shape, sample reads the ring at a phase. Only a sample
// gives a result, on the m_axis channel as a signed q15.16 amplitude.
// Configuration writes go through cfg_we / cfg_addr / cfg_wdata, to be made
// by the user only while idle; the block does not enforce this. Values are
// clamped to their legal range when written. One request is worked on at a
// time; s_axis_tready is high only when idle. Each request is paced by the
// single multiplier, which every product goes through in turn, and the one
// read port of each state memory.
// A sample result sits in an output register; a new request is taken while it
// waits, and a later sample holds in its last step until the register is free.
// Reset clears the state (held as valid bits over each memory), restores the
// register defaults and drops any pending result.
// ----------------------------------------------------------------------------
module mass_spring_ring_simulator
    import msr_pkg::*;
#(
    parameter int NUM_MASSES = 20,
    parameter int NUM_SHAPES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // strength[12:0], hammer_shape[26:13], phase[42:27]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // amplitude[31:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int CW = $clog2(NUM_MASSES);
    localparam int SW = $clog2(NUM_SHAPES);
    localparam int MW = $clog2(NUM_MASSES + 1);
    localparam logic [CW-1:0] LAST = CW'(NUM_MASSES - 1);
    localparam logic [14:0]   SH_MAX = 15'((NUM_SHAPES - 1) * 4096);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_V_RD  = 5'd1;
    localparam logic [4:0] ST_V_MUL = 5'd2;
    localparam logic [4:0] ST_V_WR  = 5'd3;
    localparam logic [4:0] ST_P_RD  = 5'd4;
    localparam logic [4:0] ST_P_MUL = 5'd5;
    localparam logic [4:0] ST_P_WR  = 5'd6;
    localparam logic [4:0] ST_F_RL  = 5'd7;
    localparam logic [4:0] ST_F_RR  = 5'd8;
    localparam logic [4:0] ST_F_RI  = 5'd9;
    localparam logic [4:0] ST_F_M1  = 5'd10;
    localparam logic [4:0] ST_F_M2  = 5'd11;
    localparam logic [4:0] ST_F_M3  = 5'd12;
    localparam logic [4:0] ST_F_M4  = 5'd13;
    localparam logic [4:0] ST_F_M5  = 5'd14;
    localparam logic [4:0] ST_F_WR  = 5'd15;
    localparam logic [4:0] ST_S_RD  = 5'd16;
    localparam logic [4:0] ST_S_M1  = 5'd17;
    localparam logic [4:0] ST_S_M2  = 5'd18;
    localparam logic [4:0] ST_S_M3  = 5'd19;
    localparam logic [4:0] ST_S_M4  = 5'd20;
    localparam logic [4:0] ST_S_M5  = 5'd21;
    localparam logic [4:0] ST_S_M6  = 5'd22;
    localparam logic [4:0] ST_S_WR  = 5'd23;
    localparam logic [4:0] ST_Q_IDX = 5'd24;
    localparam logic [4:0] ST_Q_RA  = 5'd25;
    localparam logic [4:0] ST_Q_RB  = 5'd26;
    localparam logic [4:0] ST_Q_M   = 5'd27;
    localparam logic [4:0] ST_Q_ADD = 5'd28;
    localparam logic [4:0] ST_Q_OUT = 5'd29;

    // configuration, stored already clamped
    logic [15:0] im_reg;
    logic [14:0] kn_reg;
    logic [14:0] kc_reg;
    logic [14:0] kd_reg;
    logic [12:0] h_reg;

    // sequencer and request registers
    logic [4:0]    state_reg;
    logic [4:0]    state_next;
    logic [CW-1:0] i_reg;
    logic [12:0]   s_reg;
    logic [11:0]   f_reg;
    logic [SW-1:0] a_reg;
    logic [SW-1:0] b_reg;
    logic [15:0]   phase_reg;
    logic [15:0]   frac_reg;
    logic [CW-1:0] q_idx_reg;

    // datapath registers
    sample_t            hold_reg;
    sample_t            hold2_reg;
    sample_t            blend_reg;
    logic signed [33:0] sum_reg;
    logic signed [57:0] prod_reg;
    wide_t              acc_reg;

    logic    out_valid_reg;
    sample_t out_data_reg;

    // memories and their valid bits
    logic [NUM_MASSES-1:0] pos_vld_reg;
    logic [NUM_MASSES-1:0] vel_vld_reg;
    logic [NUM_MASSES-1:0] acc_vld_reg;
    logic                  pos_rvld_reg;
    logic                  vel_rvld_reg;
    logic                  acc_rvld_reg;
    logic [CW-1:0]         pos_raddr;
    logic [31:0]           pos_rdata;
    logic [31:0]           vel_rdata;
    logic [31:0]           acc_rdata;
    sample_t               pos_rd;
    sample_t               vel_rd;
    sample_t               acc_rd;
    logic                  pos_we;
    logic                  vel_we;
    logic                  acc_we;
    sample_t               pos_wdata;
    sample_t               vel_wdata;
    sample_t               acc_wdata;

    logic [CW-1:0] i_left;
    logic [CW-1:0] i_right;
    logic [CW-1:0] q_nxt;
    logic          i_last;

    logic signed [39:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [57:0] mul_p;

    sample_t rom_a;
    sample_t rom_b;

    logic              accept;
    logic [12:0]       in_strength;
    logic [14:0]       in_shape;
    logic [14:0]       shape_c;
    logic [2:0]        shape_int;
    logic [15+MW:0]    mix;

    msr_ram #(.WIDTH(32), .DEPTH(NUM_MASSES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (i_reg),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    msr_ram #(.WIDTH(32), .DEPTH(NUM_MASSES)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (i_reg),
        .wdata (vel_wdata),
        .raddr (i_reg),
        .rdata (vel_rdata)
    );

    msr_ram #(.WIDTH(32), .DEPTH(NUM_MASSES)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (i_reg),
        .wdata (acc_wdata),
        .raddr (i_reg),
        .rdata (acc_rdata)
    );

    msr_hammer_rom #(.NUM_MASSES(NUM_MASSES), .NUM_SHAPES(NUM_SHAPES)) u_rom (
        .a_sel (a_reg),
        .b_sel (b_reg),
        .idx   (i_reg),
        .a_val (rom_a),
        .b_val (rom_b)
    );

    // ring neighbours and handshake
    assign i_last  = (i_reg == LAST);
    assign i_left  = (i_reg == '0) ? LAST : i_reg - CW'(1);
    assign i_right = i_last ? '0 : i_reg + CW'(1);
    assign q_nxt   = (q_idx_reg == LAST) ? '0 : q_idx_reg + CW'(1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // unwritten entries read as zero
    assign pos_rd = pos_rvld_reg ? pos_rdata : '0;
    assign vel_rd = vel_rvld_reg ? vel_rdata : '0;
    assign acc_rd = acc_rvld_reg ? acc_rdata : '0;

    // request field clamping
    assign in_strength = (s_axis_tdata[12:0] > 13'd4096) ? 13'd4096 : s_axis_tdata[12:0];
    assign in_shape    = {1'b0, s_axis_tdata[26:13]};
    assign shape_c     = (in_shape > SH_MAX) ? SH_MAX : in_shape;
    assign shape_int   = shape_c[14:12];
    assign mix         = (16 + MW)'(phase_reg) * (16 + MW)'(NUM_MASSES);

    // position read address
    always_comb
    begin
        unique case (state_reg)
            ST_F_RL: pos_raddr = i_left;
            ST_F_RR: pos_raddr = i_right;
            ST_Q_RA: pos_raddr = q_idx_reg;
            ST_Q_RB: pos_raddr = q_nxt;
            default: pos_raddr = i_reg;
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        unique case (state_reg)
            ST_V_MUL:
            begin
                mul_a = 40'(acc_rd);
                mul_b = $signed(18'(h_reg));
            end
            ST_P_MUL:
            begin
                mul_a = 40'(vel_rd);
                mul_b = $signed(18'(h_reg));
            end
            ST_F_M1:
            begin
                mul_a = 40'(sum_reg) - (40'(pos_rd) <<< 1);
                mul_b = $signed(18'(kn_reg));
            end
            ST_F_M2:
            begin
                mul_a = 40'(hold_reg);
                mul_b = $signed(18'(kc_reg));
            end
            ST_F_M3:
            begin
                mul_a = 40'(hold2_reg);
                mul_b = $signed(18'(kd_reg));
            end
            ST_F_M5:
            begin
                mul_a = 40'(rnd(acc_reg, 12));
                mul_b = $signed(18'(im_reg));
            end
            ST_S_M1:
            begin
                mul_a = 40'(rom_a);
                mul_b = $signed(18'(13'd4096 - 13'(f_reg)));
            end
            ST_S_M2:
            begin
                mul_a = 40'(rom_b);
                mul_b = $signed(18'(f_reg));
            end
            ST_S_M4:
            begin
                mul_a = 40'(hold_reg);
                mul_b = $signed(18'(13'd4096 - s_reg));
            end
            ST_S_M5:
            begin
                mul_a = 40'(blend_reg);
                mul_b = $signed(18'(s_reg));
            end
            ST_Q_RB:
            begin
                mul_a = 40'(pos_rd);
                mul_b = $signed(18'(17'h10000 - 17'(frac_reg)));
            end
            ST_Q_M:
            begin
                mul_a = 40'(pos_rd);
                mul_b = $signed(18'(frac_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // memory writes
    assign vel_we    = (state_reg == ST_V_WR);
    assign pos_we    = (state_reg == ST_P_WR) || (state_reg == ST_S_WR);
    assign acc_we    = (state_reg == ST_F_WR);
    assign vel_wdata = sat32(64'(hold_reg) + rnd(64'(prod_reg), 16));
    assign acc_wdata = sat32(rnd(64'(prod_reg), 12));
    assign pos_wdata = (state_reg == ST_S_WR) ? sat32(rnd(acc_reg, 12))
                                              : sat32(64'(hold_reg) + rnd(64'(prod_reg), 16));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_axis_tuser)
                        OP_TICK:   state_next = ST_V_RD;
                        OP_STRIKE: state_next = ST_S_RD;
                        OP_SAMPLE: state_next = ST_Q_IDX;
                        OP_NONE:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_V_RD:  state_next = ST_V_MUL;
            ST_V_MUL: state_next = ST_V_WR;
            ST_V_WR:  state_next = i_last ? ST_P_RD : ST_V_RD;
            ST_P_RD:  state_next = ST_P_MUL;
            ST_P_MUL: state_next = ST_P_WR;
            ST_P_WR:  state_next = i_last ? ST_F_RL : ST_P_RD;
            ST_F_RL:  state_next = ST_F_RR;
            ST_F_RR:  state_next = ST_F_RI;
            ST_F_RI:  state_next = ST_F_M1;
            ST_F_M1:  state_next = ST_F_M2;
            ST_F_M2:  state_next = ST_F_M3;
            ST_F_M3:  state_next = ST_F_M4;
            ST_F_M4:  state_next = ST_F_M5;
            ST_F_M5:  state_next = ST_F_WR;
            ST_F_WR:  state_next = i_last ? ST_IDLE : ST_F_RL;
            ST_S_RD:  state_next = ST_S_M1;
            ST_S_M1:  state_next = ST_S_M2;
            ST_S_M2:  state_next = ST_S_M3;
            ST_S_M3:  state_next = ST_S_M4;
            ST_S_M4:  state_next = ST_S_M5;
            ST_S_M5:  state_next = ST_S_M6;
            ST_S_M6:  state_next = ST_S_WR;
            ST_S_WR:  state_next = i_last ? ST_IDLE : ST_S_RD;
            ST_Q_IDX: state_next = ST_Q_RA;
            ST_Q_RA:  state_next = ST_Q_RB;
            ST_Q_RB:  state_next = ST_Q_M;
            ST_Q_M:   state_next = ST_Q_ADD;
            ST_Q_ADD: state_next = ST_Q_OUT;
            ST_Q_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            pos_vld_reg   <= '0;
            vel_vld_reg   <= '0;
            acc_vld_reg   <= '0;
            pos_rvld_reg  <= 1'b0;
            vel_rvld_reg  <= 1'b0;
            acc_rvld_reg  <= 1'b0;
            im_reg        <= 16'd40960;
            kn_reg        <= '0;
            kc_reg        <= '0;
            kd_reg        <= '0;
            h_reg         <= 13'd6554;
        end
        else
        begin
            state_reg    <= state_next;
            pos_rvld_reg <= pos_vld_reg[pos_raddr];
            vel_rvld_reg <= vel_vld_reg[i_reg];
            acc_rvld_reg <= acc_vld_reg[i_reg];
            if (pos_we)
            begin
                pos_vld_reg[i_reg] <= 1'b1;
            end
            if (vel_we)
            begin
                vel_vld_reg[i_reg] <= 1'b1;
            end
            if (acc_we)
            begin
                acc_vld_reg[i_reg] <= 1'b1;
            end

            // mass counter steps at each write
            if (accept)
            begin
                i_reg <= '0;
            end
            else if (pos_we || vel_we || acc_we)
            begin
                i_reg <= i_last ? '0 : i_reg + CW'(1);
            end

            // output register
            if (state_reg == ST_Q_OUT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // configuration writes, clamped
            if (cfg_we)
            begin
                priority case (cfg_addr)
                    CFG_INV_MASS:
                        im_reg <= (cfg_wdata < 16'd819)   ? 16'd819 :
                                  (cfg_wdata > 16'd40960) ? 16'd40960 : cfg_wdata;
                    CFG_NEIGHBOUR:
                        kn_reg <= (cfg_wdata[14:0] > 15'd20480) ? 15'd20480 : cfg_wdata[14:0];
                    CFG_CENTERING:
                        kc_reg <= (cfg_wdata[14:0] > 15'd20480) ? 15'd20480 : cfg_wdata[14:0];
                    CFG_DAMPING:
                        kd_reg <= (cfg_wdata[14:0] > 15'd20480) ? 15'd20480 : cfg_wdata[14:0];
                    CFG_TIME_STEP:
                        h_reg  <= (cfg_wdata[12:0] < 13'd66)   ? 13'd66 :
                                  (cfg_wdata[12:0] > 13'd6554) ? 13'd6554 : cfg_wdata[12:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        // request capture
        if (accept)
        begin
            s_reg     <= in_strength;
            f_reg     <= shape_c[11:0];
            a_reg     <= SW'(shape_int);
            b_reg     <= (shape_int == 3'(NUM_SHAPES - 1)) ? '0 : SW'(shape_int + 3'd1);
            phase_reg <= s_axis_tdata[42:27];
        end

        unique case (state_reg)
            ST_V_MUL: hold_reg <= vel_rd;
            ST_P_MUL: hold_reg <= pos_rd;
            ST_F_RR:  sum_reg  <= 34'(pos_rd);
            ST_F_RI:  sum_reg  <= sum_reg + 34'(pos_rd);
            ST_F_M1:
            begin
                hold_reg  <= pos_rd;
                hold2_reg <= vel_rd;
            end
            ST_F_M2:  acc_reg <= 64'(prod_reg);
            ST_F_M3:  acc_reg <= acc_reg - 64'(prod_reg);
            ST_F_M4:  acc_reg <= acc_reg - 64'(prod_reg);
            ST_S_M1:  hold_reg <= pos_rd;
            ST_S_M2:  acc_reg  <= 64'(prod_reg);
            ST_S_M3:  acc_reg  <= acc_reg + 64'(prod_reg);
            ST_S_M4:  blend_reg <= 32'(rnd(acc_reg, 12));
            ST_S_M5:  acc_reg  <= 64'(prod_reg);
            ST_S_M6:  acc_reg  <= acc_reg + 64'(prod_reg);
            ST_Q_IDX:
            begin
                q_idx_reg <= mix[16 +: CW];
                frac_reg  <= mix[15:0];
            end
            ST_Q_M:   acc_reg <= 64'(prod_reg);
            ST_Q_ADD: acc_reg <= acc_reg + 64'(prod_reg);
            default: ;
        endcase

        if (state_reg == ST_Q_OUT && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= sat32(rnd(acc_reg, 16));
        end
    end

endmodule

FILE: hdl/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks on the ring simulator, bound to the top level
// ----------------------------------------------------------------------------
module msr_checker
    import msr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a real request keeps the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_NONE) |=> !s_axis_tready)
        else $error("request taken without going busy");

    // results only come out of work in progress
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind mass_spring_ring_simulator msr_checker u_msr_checker (.*);
